// ===== hw/rtl/cwbc_pkg.sv =====
package cwbc_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;
   localparam int FIELD_BITS     = 32;
   localparam int CSR_BITS       = 5;
   localparam logic [CSR_BITS-1:0] CSR_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FILL  = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_HIT   = 2'd0,
      KIND_MISS  = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_WBACK = 2'd3
   } kind_type;

   typedef struct packed {
      op_type                operation;
      logic [FIELD_BITS-1:0] lookup_key;
      logic [FIELD_BITS-1:0] write_data;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [FIELD_BITS-1:0] result_key;
      logic [FIELD_BITS-1:0] result_data;
      logic                  last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_EMIT,
      ST_FLUSH,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/clock_writeback_cache.sv =====
// A read returns a hit or miss response; a write or fill that hits or finds a free entry
// returns done, and one that sweeps first clears reference marks up to an unmarked entry
// and emits a writeback before done if that entry is dirty.
// One read per cycle while the response output is not stalled; a write or fill holds the
// back end until its done response, and a flush holds it while it walks every live entry.
// Reset clears marks, fill count, hand and queue; the entry count reads 16.
module clock_writeback_cache #(
   parameter int CAPACITY   = cwbc_pkg::CAPACITY_DEF,
   parameter int KEY_BITS   = cwbc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = cwbc_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cwbc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cwbc_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cwbc_pkg::CSR_BITS-1:0] csr_data
);
   import cwbc_pkg::*;

   logic [CSR_BITS-1:0] csr_ff;
   logic                q_valid, q_ready;
   req_type             q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_valid) begin
         csr_ff <= csr_data;
      end
   end

   cwbc_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data)
   );

   cwbc_back #(.CAPACITY(CAPACITY)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cap_reg   (csr_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

// ===== hw/rtl/cwbc_queue.sv =====
module cwbc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] data_ff [2];
   logic [WIDTH-1:0] data_in [2];
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = data_ff[0];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      data_in  = data_ff;
      count_in = count_ff;
      if (pop) begin
         data_in[0] = data_ff[1];
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
            data_in[0] = in_data;
         end else begin
            data_in[1] = in_data;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

// ===== hw/rtl/cwbc_front.sv =====
module cwbc_front #(
   parameter int KEY_BITS   = cwbc_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = cwbc_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cwbc_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_ready,
   output cwbc_pkg::req_type q_data
);
   import cwbc_pkg::*;

   req_type in_clean;

   always_comb begin
      in_clean = req_data;
      in_clean.lookup_key = req_data.lookup_key &
                            FIELD_BITS'((65'd1 << KEY_BITS) - 65'd1);
      in_clean.write_data = req_data.write_data &
                            FIELD_BITS'((65'd1 << VALUE_BITS) - 65'd1);
      if (req_data.operation == OP_FLUSH || req_data.operation == OP_READ) begin
         in_clean.write_data = '0;
      end
   end

   cwbc_queue #(.WIDTH($bits(req_type))) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (in_clean),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );
endmodule

// ===== hw/rtl/cwbc_back.sv =====
module cwbc_back #(
   parameter int CAPACITY = cwbc_pkg::CAPACITY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [cwbc_pkg::CSR_BITS-1:0]   cap_reg,
   input  logic                            q_valid,
   output logic                            q_ready,
   input  cwbc_pkg::req_type               q_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cwbc_pkg::rsp_type               rsp_data
);
   import cwbc_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = (CW > CSR_BITS) ? CW : CSR_BITS;

   logic [FIELD_BITS-1:0] keys_ff [CAPACITY];
   logic [FIELD_BITS-1:0] vals_ff [CAPACITY];
   logic [CAPACITY-1:0]   ref_ff, ref_in, dirty_ff, dirty_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [IW-1:0]         hand_ff, hand_in;
   logic [IW-1:0]         idx_ff, idx_in;
   state_type             state_ff, state_in;
   req_type               cur_ff, cur_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic                  wr_en;
   logic [IW-1:0]         wr_idx;

   logic [CW-1:0]       cap, live;
   logic [CAPACITY-1:0] match;
   logic                hit;
   logic [IW-1:0]       hit_idx;
   logic                out_free;
   logic [IW-1:0]       hand_next;

   always_comb begin
      logic [MW-1:0] c;
      c = MW'(cap_reg);
      cap = (c < MW'(CAPACITY)) ? CW'(c) : CW'(CAPACITY);
      live = (fill_ff < cap) ? fill_ff : cap;
   end

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = (CW'(i) < live) && (keys_ff[i] == q_data.lookup_key);
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit = 1'b1;
            hit_idx = IW'(i);
         end
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign hand_next = (CW'(idx_ff) + CW'(1) >= cap) ? '0 : IW'(CW'(idx_ff) + CW'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               if (q_data.operation == OP_FLUSH) begin
                  state_in = ST_FLUSH;
               end else if (q_data.operation != OP_READ && cap != '0 && !hit
                            && fill_ff >= cap) begin
                  state_in = ST_SWEEP;
               end else if (q_data.operation != OP_READ) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SWEEP: begin
            if (!ref_ff[idx_ff]) begin
               state_in = dirty_ff[idx_ff] ? ST_EMIT : ST_DONE;
            end
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_DONE;
         end
         ST_FLUSH: begin
            if (out_free && (live == '0 || CW'(idx_ff) + CW'(1) >= live)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ref_in       = ref_ff;
      dirty_in     = dirty_ff;
      fill_in      = fill_ff;
      hand_in      = hand_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      q_ready      = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_ready = 1'b1;
               cur_in  = q_data;
               idx_in  = '0;
               case (q_data.operation) inside
                  OP_READ: begin
                     out_valid_in = 1'b1;
                     out_in.result_key = q_data.lookup_key;
                     out_in.last = 1'b1;
                     if (cap != '0 && hit) begin
                        ref_in[hit_idx] = 1'b1;
                        out_in.kind = KIND_HIT;
                        out_in.result_data = vals_ff[hit_idx];
                     end else begin
                        out_in.kind = KIND_MISS;
                        out_in.result_data = '0;
                     end
                  end
                  OP_WRITE, OP_FILL: begin
                     if (cap == '0) begin
                        if (q_data.operation == OP_WRITE) begin
                           out_valid_in = 1'b1;
                           out_in.kind = KIND_WBACK;
                           out_in.result_key = q_data.lookup_key;
                           out_in.result_data = q_data.write_data;
                           out_in.last = 1'b0;
                        end
                     end else if (hit || fill_ff < cap) begin
                        wr_en  = 1'b1;
                        wr_idx = hit ? hit_idx : IW'(fill_ff);
                        ref_in[wr_idx]   = 1'b1;
                        dirty_in[wr_idx] = (q_data.operation == OP_WRITE);
                        if (!hit) fill_in = fill_ff + CW'(1);
                     end else begin
                        idx_in = (CW'(hand_ff) >= cap) ? '0 : hand_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            if (ref_ff[idx_ff]) begin
               ref_in[idx_ff] = 1'b0;
               idx_in = hand_next;
            end else if (!dirty_ff[idx_ff]) begin
               wr_en   = 1'b1;
               hand_in = hand_next;
               ref_in[idx_ff]   = 1'b1;
               dirty_in[idx_ff] = (cur_ff.operation == OP_WRITE);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.kind = KIND_WBACK;
               out_in.result_key = keys_ff[idx_ff];
               out_in.result_data = vals_ff[idx_ff];
               out_in.last = 1'b0;
               wr_en   = 1'b1;
               hand_in = hand_next;
               ref_in[idx_ff]   = 1'b1;
               dirty_in[idx_ff] = (cur_ff.operation == OP_WRITE);
            end
         end
         ST_FLUSH: begin
            if (out_free && live != '0) begin
               if (dirty_ff[idx_ff]) begin
                  out_valid_in = 1'b1;
                  out_in.kind = KIND_WBACK;
                  out_in.result_key = keys_ff[idx_ff];
                  out_in.result_data = vals_ff[idx_ff];
                  out_in.last = 1'b0;
                  dirty_in[idx_ff] = 1'b0;
               end
               idx_in = IW'(CW'(idx_ff) + CW'(1));
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.kind = KIND_DONE;
               out_in.result_key = '0;
               out_in.result_data = '0;
               out_in.last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      cur_ff <= cur_in;
      if (wr_en) begin
         keys_ff[wr_idx] <= (state_ff == ST_IDLE) ? q_data.lookup_key : cur_ff.lookup_key;
         vals_ff[wr_idx] <= (state_ff == ST_IDLE) ? q_data.write_data : cur_ff.write_data;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         ref_ff       <= '0;
         dirty_ff     <= '0;
         fill_ff      <= '0;
         hand_ff      <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_ff       <= ref_in;
         dirty_ff     <= dirty_in;
         fill_ff      <= fill_in;
         hand_ff      <= hand_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY)) else $error("fill count over capacity");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_ready |-> state_ff == ST_IDLE) else $error("item taken while busy");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_DONE |-> rsp_data.last)
      else $error("done without last");
endmodule

// ===== test/tb.sv =====
module tb;
   import cwbc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_BITS-1:0] csr_data = '0;

   clock_writeback_cache dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // cache image
   logic [31:0] line_key [16];
   logic [31:0] line_val [16];
   logic        line_ref [16];
   logic        line_dirty [16];
   int unsigned fill_count;
   int unsigned hand;
   int unsigned size_reg;

   rsp_type pending_rsp [$];
   int      fail_count = 0;
   int      cycles = 0;
   bit      calm = 1'b0;

   function automatic void push_rsp(kind_type k, logic [31:0] key, logic [31:0] data);
      rsp_type r;
      r.kind = k;
      r.result_key = key;
      r.result_data = data;
      r.last = 1'b0;
      pending_rsp.push_back(r);
   endfunction

   function automatic int find_line(int unsigned n, logic [31:0] key);
      for (int i = 0; i < n; i++) begin
         if (line_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic void predict_cache(req_type rq);
      int unsigned cap;
      int unsigned n;
      int hit;
      int unsigned slot;
      cap = (size_reg < 16) ? size_reg : 16;
      n = (fill_count < cap) ? fill_count : cap;
      case (rq.operation) inside
         OP_READ: begin
            hit = (cap == 0) ? -1 : find_line(n, rq.lookup_key);
            if (hit >= 0) begin
               line_ref[hit] = 1'b1;
               push_rsp(KIND_HIT, rq.lookup_key, line_val[hit]);
            end else begin
               push_rsp(KIND_MISS, rq.lookup_key, '0);
            end
         end
         OP_WRITE, OP_FILL: begin
            if (cap == 0) begin
               if (rq.operation == OP_WRITE) push_rsp(KIND_WBACK, rq.lookup_key, rq.write_data);
            end else begin
               hit = find_line(n, rq.lookup_key);
               if (hit >= 0) begin
                  slot = hit;
               end else if (fill_count < cap) begin
                  slot = fill_count;
                  fill_count++;
               end else begin
                  if (hand >= cap) hand = 0;
                  for (int s = 0; s < 2 * cap + 1; s++) begin
                     if (!line_ref[hand]) break;
                     line_ref[hand] = 1'b0;
                     hand = (hand + 1) % cap;
                  end
                  slot = hand;
                  if (line_dirty[slot]) push_rsp(KIND_WBACK, line_key[slot], line_val[slot]);
                  hand = (hand + 1) % cap;
               end
               line_key[slot] = rq.lookup_key;
               line_val[slot] = rq.write_data;
               line_ref[slot] = 1'b1;
               line_dirty[slot] = (rq.operation == OP_WRITE);
            end
            push_rsp(KIND_DONE, '0, '0);
         end
         default: begin
            for (int i = 0; i < n; i++) begin
               if (line_dirty[i]) begin
                  push_rsp(KIND_WBACK, line_key[i], line_val[i]);
                  line_dirty[i] = 1'b0;
               end
            end
            push_rsp(KIND_DONE, '0, '0);
         end
      endcase
      pending_rsp[pending_rsp.size() - 1].last = 1'b1;
   endfunction

   // response check and sink stalls
   int stall_left = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response expected none actual %p", $time, rsp_data);
            fail_count++;
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (e !== rsp_data) begin
               $display("%0t: response mismatch expected %p actual %p", $time, e, rsp_data);
               fail_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("** clock_writeback_cache: FAILED **");
         $finish;
      end
   end

   task automatic send_req(op_type op, logic [31:0] key, logic [31:0] data);
      req_type rq;
      rq.operation = op;
      rq.lookup_key = key;
      rq.write_data = data;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      predict_cache(rq);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_size(int unsigned v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v[CSR_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = v;
   endtask

   typedef struct {
      op_type      op;
      logic [31:0] key;
      logic [31:0] data;
      bit          typed;
      kind_type    k;
      logic [31:0] rk;
      logic [31:0] rd;
   } row_type;

   row_type stim_rows [10] = '{
      '{OP_READ,  32'h0000_0000, 32'h0,         1, KIND_MISS, 32'h0000_0000, 32'h0},
      '{OP_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, KIND_MISS, 32'hFFFF_FFFF, 32'h0},
      '{OP_FLUSH, 32'h0,         32'h0,         1, KIND_DONE, 32'h0, 32'h0},
      '{OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, KIND_DONE, 32'h0, 32'h0},
      '{OP_READ,  32'hFFFF_FFFF, 32'h0,         1, KIND_HIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{OP_FILL,  32'h0000_0000, 32'h0,         1, KIND_DONE, 32'h0, 32'h0},
      '{OP_FILL,  32'hFFFF_FFFF, 32'h1234_5678, 0, KIND_DONE, 32'h0, 32'h0},
      '{OP_WRITE, 32'h8000_0001, 32'hA5A5_5A5A, 0, KIND_DONE, 32'h0, 32'h0},
      '{OP_FLUSH, 32'hDEAD_BEEF, 32'h0,         0, KIND_DONE, 32'h0, 32'h0},
      '{OP_READ,  32'h8000_0001, 32'h0,         0, KIND_DONE, 32'h0, 32'h0}
   };

   task automatic random_phase(int count, int unsigned key_span);
      for (int i = 0; i < count; i++) begin
         int unsigned r;
         logic [31:0] key;
         r = $urandom_range(0, 9);
         key = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, key_span);
         if (r < 4) send_req(OP_READ, key, $urandom());
         else if (r < 7) send_req(OP_WRITE, key, $urandom());
         else if (r < 9) send_req(OP_FILL, key, $urandom());
         else send_req(OP_FLUSH, $urandom(), $urandom());
      end
   endtask

   initial begin
      rsp_type e;
      for (int i = 0; i < 16; i++) begin
         line_key[i] = '0;
         line_val[i] = '0;
         line_ref[i] = 1'b0;
         line_dirty[i] = 1'b0;
      end
      fill_count = 0;
      hand = 0;
      size_reg = 16;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         send_req(stim_rows[i].op, stim_rows[i].key, stim_rows[i].data);
         if (stim_rows[i].typed) begin
            e = pending_rsp[pending_rsp.size() - 1];
            if (e.kind !== stim_rows[i].k || e.result_key !== stim_rows[i].rk
                || e.result_data !== stim_rows[i].rd) begin
               $display("%0t: row %0d expected %0d %h %h actual %0d %h %h", $time, i,
                        stim_rows[i].k, stim_rows[i].rk, stim_rows[i].rd,
                        e.kind, e.result_key, e.result_data);
               fail_count++;
            end
         end
      end
      // fill past capacity to force sweeps and writebacks
      for (int i = 0; i < 15; i++) send_req(OP_WRITE, 32'h100 + i, $urandom());

      random_phase(90, 40);
      write_size(0);
      send_req(OP_WRITE, 32'h0, 32'hFFFF_FFFF);
      send_req(OP_READ, 32'h0, 32'h0);
      send_req(OP_FILL, 32'h1, 32'h1);
      send_req(OP_FLUSH, 32'h0, 32'h0);
      random_phase(20, 20);
      write_size(1);
      random_phase(50, 4);
      write_size(4);
      random_phase(80, 10);
      write_size(31);
      random_phase(80, 30);
      write_size(9);
      random_phase(50, 20);
      calm = 1'b1;
      write_size(16);
      random_phase(30, 24);
      drain();
      if (fail_count == 0) begin
         $display("** clock_writeback_cache: PASSED **");
      end else begin
         $display("** clock_writeback_cache: FAILED **");
      end
      $finish;
   end
endmodule

// ===== clock_writeback_cache.f =====
hw/rtl/cwbc_pkg.sv
hw/rtl/cwbc_queue.sv
hw/rtl/cwbc_front.sv
hw/rtl/cwbc_back.sv
hw/rtl/clock_writeback_cache.sv
test/tb.sv
